/* rtl/tam_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// tam_pkg
// Shared types and constants of the tile average mosaic block: pixel and
// tile items, the job handed from the accumulator to the divider, register
// indexes and fixed field widths.
// ============================================================================

package tam_pkg;

    localparam int CFG_W      = 12;
    localparam int IDX_W      = 1;
    localparam int CHAN_W     = 8;
    localparam int ROW_W      = 11;
    localparam int TILE_IDX_W = 9;
    localparam int MAX_HEIGHT = 2048;

    // widest per-channel tile sum over the whole TILE_SIZE range (16 x 16 x 255)
    localparam int SUM_MAX_W  = 16;
    // pixel count of one tile, up to 256
    localparam int COUNT_W    = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_start;
    } pixel_t;

    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile_column;
        logic [TILE_IDX_W-1:0] tile_row;
        logic [CHAN_W-1:0]     red_average;
        logic [CHAN_W-1:0]     green_average;
        logic [CHAN_W-1:0]     blue_average;
        logic                  last_tile;
    } tile_t;

    typedef struct packed {
        logic [TILE_IDX_W-1:0] tile_column;
        logic [TILE_IDX_W-1:0] tile_row;
        logic                  last_tile;
        logic [COUNT_W-1:0]    count;
        logic [SUM_MAX_W-1:0]  sum_red;
        logic [SUM_MAX_W-1:0]  sum_green;
        logic [SUM_MAX_W-1:0]  sum_blue;
    } job_t;

endpackage

/* rtl/tam_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// tam_front
// Pixel front end: tracks raster and in-tile position, keeps the per tile
// column channel sums in a memory and hands each finished tile as a job.
// ============================================================================

module tam_front #(
    parameter int TILE_SIZE = 6,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tam_pkg::CFG_W-1:0] frame_width,
    input  logic [tam_pkg::CFG_W-1:0] frame_height,
    input  tam_pkg::pixel_t           pixel,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    output tam_pkg::job_t             job,
    output logic                      job_valid,
    input  logic                      job_ready
);

    localparam int TILE_COLUMNS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
    localparam int TC_W  = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CIT_W = $clog2(TILE_SIZE);
    localparam int DIM_W = (COL_W + 1 > tam_pkg::CFG_W) ? COL_W + 1 : tam_pkg::CFG_W;
    localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * 255 + 1);
    localparam int WORD_W = 3 * SUM_W;

    logic [COL_W-1:0]               col_pos_reg, col_pos_next, cur_col;
    logic [tam_pkg::ROW_W-1:0]      row_pos_reg, row_pos_next, cur_row;
    logic [CIT_W-1:0]               cit_reg, cit_next, cur_cit;
    logic [CIT_W-1:0]               rit_reg, rit_next, cur_rit;
    logic [TC_W-1:0]                tcol_reg, tcol_next, cur_tcol;
    logic [tam_pkg::TILE_IDX_W-1:0] trow_reg, trow_next, cur_trow;

    logic [DIM_W-1:0]               width_ext, width_lim;
    logic [tam_pkg::CFG_W-1:0]      height_lim;
    logic                           row_end, last_row, frame_end, tile_done;
    logic                           cit_last, rit_last;
    logic [tam_pkg::COUNT_W-1:0]    count;
    logic                           pixel_accept;

    logic [WORD_W-1:0]              sums_mem [TILE_COLUMNS];
    logic [WORD_W-1:0]              rd_data_reg;
    logic                           fwd_hit_reg;
    logic [WORD_W-1:0]              fwd_data_reg;

    logic                           b_valid_reg;
    tam_pkg::pixel_t                b_pixel_reg;
    logic                           b_first_col_reg;
    logic                           b_first_row_reg;
    logic [TC_W-1:0]                b_addr_reg;
    logic [tam_pkg::TILE_IDX_W-1:0] b_trow_reg;
    logic                           b_done_reg;
    logic                           b_last_reg;
    logic [tam_pkg::COUNT_W-1:0]    b_count_reg;
    logic                           b_fire;

    logic [SUM_W-1:0]               acc_reg  [3];
    logic [SUM_W-1:0]               acc_next [3];
    logic [tam_pkg::CHAN_W-1:0]     px       [3];
    logic [WORD_W-1:0]              base_word;
    logic [WORD_W-1:0]              acc_word;

    // position after an optional frame restart
    always_comb
    begin
        cur_col  = pixel.frame_start ? '0 : col_pos_reg;
        cur_row  = pixel.frame_start ? '0 : row_pos_reg;
        cur_cit  = pixel.frame_start ? '0 : cit_reg;
        cur_rit  = pixel.frame_start ? '0 : rit_reg;
        cur_tcol = pixel.frame_start ? '0 : tcol_reg;
        cur_trow = pixel.frame_start ? '0 : trow_reg;
    end

    always_comb
    begin
        width_ext = DIM_W'(frame_width);
        if (width_ext == '0)
            width_lim = DIM_W'(1);
        else if (width_ext > DIM_W'(MAX_WIDTH))
            width_lim = DIM_W'(MAX_WIDTH);
        else
            width_lim = width_ext;

        if (frame_height == '0)
            height_lim = tam_pkg::CFG_W'(1);
        else if (frame_height > tam_pkg::CFG_W'(tam_pkg::MAX_HEIGHT))
            height_lim = tam_pkg::CFG_W'(tam_pkg::MAX_HEIGHT);
        else
            height_lim = frame_height;
    end

    assign row_end   = DIM_W'(cur_col) >= width_lim - DIM_W'(1);
    assign last_row  = tam_pkg::CFG_W'(cur_row) >= height_lim - tam_pkg::CFG_W'(1);
    assign frame_end = row_end && last_row;
    assign cit_last  = cur_cit == CIT_W'(TILE_SIZE - 1);
    assign rit_last  = cur_rit == CIT_W'(TILE_SIZE - 1);
    assign tile_done = (cit_last || row_end) && (rit_last || last_row);
    assign count     = (tam_pkg::COUNT_W'(cur_cit) + tam_pkg::COUNT_W'(1))
                     * (tam_pkg::COUNT_W'(cur_rit) + tam_pkg::COUNT_W'(1));

    always_comb
    begin
        col_pos_next = cur_col;
        row_pos_next = cur_row;
        cit_next     = cur_cit;
        rit_next     = cur_rit;
        tcol_next    = cur_tcol;
        trow_next    = cur_trow;
        if (row_end)
        begin
            col_pos_next = '0;
            cit_next     = '0;
            tcol_next    = '0;
            if (frame_end)
            begin
                row_pos_next = '0;
                rit_next     = '0;
                trow_next    = '0;
            end
            else
            begin
                row_pos_next = cur_row + tam_pkg::ROW_W'(1);
                rit_next     = rit_last ? '0 : cur_rit + CIT_W'(1);
                trow_next    = rit_last ? cur_trow + tam_pkg::TILE_IDX_W'(1) : cur_trow;
            end
        end
        else
        begin
            col_pos_next = cur_col + COL_W'(1);
            cit_next     = cit_last ? '0 : cur_cit + CIT_W'(1);
            tcol_next    = cit_last ? cur_tcol + TC_W'(1) : cur_tcol;
        end
    end

    assign b_fire       = b_valid_reg && (!b_done_reg || job_ready);
    assign pixel_ready  = !b_valid_reg || b_fire;
    assign pixel_accept = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            cit_reg     <= '0;
            rit_reg     <= '0;
            tcol_reg    <= '0;
            trow_reg    <= '0;
        end
        else if (pixel_accept)
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            cit_reg     <= cit_next;
            rit_reg     <= rit_next;
            tcol_reg    <= tcol_next;
            trow_reg    <= trow_next;
        end
    end

    // sum memory: read at accept, written by every item leaving the second stage
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
            rd_data_reg <= sums_mem[cur_tcol];
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
            sums_mem[b_addr_reg] <= acc_word;
    end

    // bypass for a write landing on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (pixel_accept)
            fwd_hit_reg <= b_fire && (b_addr_reg == cur_tcol);
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
            fwd_data_reg <= acc_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (pixel_ready)
            b_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            b_pixel_reg     <= pixel;
            b_first_col_reg <= cur_cit == '0;
            b_first_row_reg <= cur_rit == '0;
            b_addr_reg      <= cur_tcol;
            b_trow_reg      <= cur_trow;
            b_done_reg      <= tile_done;
            b_last_reg      <= frame_end;
            b_count_reg     <= count;
        end
    end

    assign base_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        px[0] = b_pixel_reg.blue;
        px[1] = b_pixel_reg.green;
        px[2] = b_pixel_reg.red;
        for (int c = 0; c < 3; c++)
        begin
            if (!b_first_col_reg)
                acc_next[c] = acc_reg[c] + SUM_W'(px[c]);
            else if (b_first_row_reg)
                acc_next[c] = SUM_W'(px[c]);
            else
                acc_next[c] = base_word[c*SUM_W +: SUM_W] + SUM_W'(px[c]);
            acc_word[c*SUM_W +: SUM_W] = acc_next[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= acc_next[c];
        end
    end

    assign job_valid       = b_valid_reg && b_done_reg;
    assign job.tile_column = tam_pkg::TILE_IDX_W'(b_addr_reg);
    assign job.tile_row    = b_trow_reg;
    assign job.last_tile   = b_last_reg;
    assign job.count       = b_count_reg;
    assign job.sum_red     = tam_pkg::SUM_MAX_W'(acc_next[2]);
    assign job.sum_green   = tam_pkg::SUM_MAX_W'(acc_next[1]);
    assign job.sum_blue    = tam_pkg::SUM_MAX_W'(acc_next[0]);

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_fire |=> b_valid_reg && $stable(b_addr_reg) && $stable(b_count_reg))
        else $error("stalled tile job changed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job.count != '0)
        else $error("tile job with zero pixel count");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_accept |=> b_valid_reg)
        else $error("accepted item lost before accumulation");

endmodule

/* rtl/tam_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// tam_queue
// Short job queue between the accumulating front end and the divider, so
// that each side stalls on its own.
// ============================================================================

module tam_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  tam_pkg::job_t push_job,
    input  logic          push_valid,
    output logic          push_ready,
    output tam_pkg::job_t pop_job,
    output logic          pop_valid,
    input  logic          pop_ready
);

    tam_pkg::job_t                entries [tam_pkg::QUEUE_DEPTH];
    logic [tam_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tam_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tam_pkg::QPTR_W:0]     fill_reg;
    logic                         push, pop;

    assign push_ready = fill_reg != (tam_pkg::QPTR_W + 1)'(tam_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + tam_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + tam_pkg::QPTR_W'(1);
            if (push && !pop)
                fill_reg <= fill_reg + (tam_pkg::QPTR_W + 1)'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - (tam_pkg::QPTR_W + 1)'(1);
        end
    end

endmodule

/* rtl/tam_divider.sv */
`timescale 1ns / 1ps
// ============================================================================
// tam_divider
// Back end: divides the three channel sums of a tile by its pixel count,
// one quotient bit per cycle for all channels at once, and holds the tile
// item in an output register.
// ============================================================================

module tam_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  tam_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_ready,
    output tam_pkg::tile_t tile,
    output logic          tile_valid,
    input  logic          tile_ready
);

    localparam int STEP_W = $clog2(tam_pkg::CHAN_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } div_state_t;

    div_state_t                     state_reg, state_next;
    logic [STEP_W-1:0]              step_reg;
    logic [tam_pkg::SUM_MAX_W-1:0]  rem_reg  [3];
    logic [tam_pkg::SUM_MAX_W-1:0]  rem_next [3];
    logic [tam_pkg::CHAN_W-1:0]     quot_reg [3];
    logic [tam_pkg::CHAN_W-1:0]     quot_next [3];
    logic [tam_pkg::SUM_MAX_W-1:0]  dsh_reg;
    tam_pkg::job_t                  job_reg;
    tam_pkg::tile_t                 tile_reg;
    logic                           tile_valid_reg;
    logic                           out_free;
    logic                           load, finish;

    assign out_free  = !tile_valid_reg || tile_ready;
    assign job_ready = state_reg == ST_IDLE;
    assign load      = job_valid && job_ready;
    assign finish    = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid)
                    state_next = ST_CALC;
            ST_CALC:
                if (step_reg == '0)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // restoring step against the shifted divisor
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (rem_reg[c] >= dsh_reg)
            begin
                rem_next[c]  = rem_reg[c] - dsh_reg;
                quot_next[c] = {quot_reg[c][tam_pkg::CHAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c]  = rem_reg[c];
                quot_next[c] = {quot_reg[c][tam_pkg::CHAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg    <= job;
            step_reg   <= STEP_W'(tam_pkg::CHAN_W - 1);
            dsh_reg    <= tam_pkg::SUM_MAX_W'(job.count) << (tam_pkg::CHAN_W - 1);
            rem_reg[0] <= job.sum_blue;
            rem_reg[1] <= job.sum_green;
            rem_reg[2] <= job.sum_red;
            for (int c = 0; c < 3; c++)
                quot_reg[c] <= '0;
        end
        else if (state_reg == ST_CALC)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg != '0)
                dsh_reg <= dsh_reg >> 1;
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[c]  <= rem_next[c];
                quot_reg[c] <= quot_next[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tile_valid_reg <= 1'b0;
        else if (finish)
            tile_valid_reg <= 1'b1;
        else if (tile_ready)
            tile_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            tile_reg.tile_column   <= job_reg.tile_column;
            tile_reg.tile_row      <= job_reg.tile_row;
            tile_reg.last_tile     <= job_reg.last_tile;
            tile_reg.blue_average  <= quot_reg[0];
            tile_reg.green_average <= quot_reg[1];
            tile_reg.red_average   <= quot_reg[2];
        end
    end

    assign tile       = tile_reg;
    assign tile_valid = tile_valid_reg;

    a_remainder_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> rem_reg[0] < dsh_reg && rem_reg[1] < dsh_reg
                                 && rem_reg[2] < dsh_reg)
        else $error("average does not fit the channel width");

    a_load_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg == ST_CALC)
        else $error("job taken without starting division");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> tile_valid_reg)
        else $error("finished tile not presented");

endmodule

/* rtl/tile_average_mosaic.sv */
`timescale 1ns / 1ps
// ============================================================================
// tile_average_mosaic
// Block average mosaic: accumulates BGR pixels per square tile over a raster
// frame and gives one item with the truncated channel means per tile.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  pixel     in         pixel_valid / pixel_ready    tam_pkg::pixel_t
//  tile      out        tile_valid / tile_ready      tam_pkg::tile_t
//  cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
//  the front end takes one pixel per cycle unless stalled; the sum memory read and the
//  accumulate stage form a two-stage pipeline with a write bypass
//  each finished tile passes the shared divider in order (load, 8 quotient
//  bit steps, output); a 4-deep job queue absorbs bursts of finished tiles
//  pixel input stalls only when the job queue is full
//  reset clears positions, queue and divider at once; the sum memory needs
//  no clearing since every tile starts by overwriting its entry
// ============================================================================

module tile_average_mosaic #(
    parameter int TILE_SIZE = 6,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tam_pkg::IDX_W-1:0] cfg_index,
    input  logic [tam_pkg::CFG_W-1:0] cfg_data,
    input  tam_pkg::pixel_t           pixel,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    output tam_pkg::tile_t            tile,
    output logic                      tile_valid,
    input  logic                      tile_ready
);

    logic [tam_pkg::CFG_W-1:0] frame_width_reg;
    logic [tam_pkg::CFG_W-1:0] frame_height_reg;

    tam_pkg::job_t front_job;
    logic          front_job_valid;
    logic          front_job_ready;
    tam_pkg::job_t back_job;
    logic          back_job_valid;
    logic          back_job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= tam_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= tam_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tam_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                tam_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tam_front #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pixel        (pixel),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .job          (front_job),
        .job_valid    (front_job_valid),
        .job_ready    (front_job_ready)
    );

    tam_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_job_valid),
        .push_ready (front_job_ready),
        .pop_job    (back_job),
        .pop_valid  (back_job_valid),
        .pop_ready  (back_job_ready)
    );

    tam_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (back_job),
        .job_valid  (back_job_valid),
        .job_ready  (back_job_ready),
        .tile       (tile),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready)
    );

endmodule
